// ----- rtl/core/pss_pkg.sv -----
package pss_pkg;

   // request commands
   localparam logic [1:0] CMD_SET   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_RESET = 2'd2;
   localparam logic [1:0] CMD_QUERY = 2'd3;

   // priority levels
   localparam logic [1:0] PRIO_IGNORE  = 2'd0;
   localparam logic [1:0] PRIO_DEFAULT = 2'd1;
   localparam logic [1:0] PRIO_HIGH    = 2'd2;
   localparam logic [1:0] PRIO_HIGH_ALT = 2'd3;

   // result status
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   // number of state codes the block knows
   localparam int CODE_COUNT = 16;

   // register indexes on paddr[3:2]
   localparam logic [1:0] CSR_PRIORITY_MAP = 2'd0;
   localparam logic [1:0] CSR_STATE_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_OFF_CODE     = 2'd2;

   localparam logic [31:0] PRIORITY_MAP_RST = 32'h5555_5555;
   localparam logic [4:0]  STATE_LIMIT_RST  = 5'd16;
   localparam logic [3:0]  OFF_CODE_RST     = 4'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic start;   // latch request, arm the walk
      logic step;    // examine one stack entry
      logic apply;   // commit stack update, load result word
   } dp_cmd_type;

   typedef struct packed {
      logic walk_done;
   } dp_stat_type;

   // priority of a code; level three reads as high
   function automatic logic [1:0] prio_of(input logic [31:0] map, input logic [3:0] code);
      logic [1:0] p;
      p = map[{code, 1'b0} +: 2];
      return (p == PRIO_HIGH_ALT) ? PRIO_HIGH : p;
   endfunction

endpackage

// ----- rtl/core/pss_ctrl.sv -----
module pss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pss_pkg::dp_cmd_type  dp_cmd,
   input  pss_pkg::dp_stat_type dp_stat
);

   pss_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pss_pkg::ST_IDLE: begin
            if (req_valid) state_in = pss_pkg::ST_WALK;
         end
         pss_pkg::ST_WALK: begin
            if (dp_stat.walk_done) state_in = pss_pkg::ST_APPLY;
         end
         pss_pkg::ST_APPLY: begin
            if (out_free) state_in = pss_pkg::ST_IDLE;
         end
         default: state_in = pss_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd    = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         pss_pkg::ST_IDLE: begin
            req_stall    = 1'b0;
            dp_cmd.start = req_valid;
         end
         pss_pkg::ST_WALK: begin
            dp_cmd.step = !dp_stat.walk_done;
         end
         pss_pkg::ST_APPLY: begin
            dp_cmd.apply = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // hold the result word while the receiver stalls
   assign rsp_valid_in = dp_cmd.apply || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pss_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/pss_dp.sv -----
module pss_dp #(
   parameter int STACK_DEPTH = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pss_pkg::dp_cmd_type  dp_cmd,
   output pss_pkg::dp_stat_type dp_stat,
   input  logic [1:0]           req_cmd,
   input  logic [3:0]           req_led_code,
   input  logic [31:0]          priority_map,
   input  logic [4:0]           state_limit,
   input  logic [3:0]           off_code,
   output logic                 rsp_status,
   output logic [3:0]           rsp_shown_code,
   output logic [1:0]           rsp_shown_priority,
   output logic                 rsp_display_changed
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

   logic [3:0]       stack_ff [STACK_DEPTH];
   logic [3:0]       stack_in [STACK_DEPTH];
   logic [3:0]       up_w     [STACK_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [1:0]       op_ff;
   logic [3:0]       code_ff;
   logic [3:0]       bbest_ff, abest_ff;
   logic [1:0]       bprio_ff, aprio_ff;
   logic             bfound_ff, afound_ff, mfound_ff;
   logic [IDX_W-1:0] midx_ff;
   logic             status_ff;
   logic [3:0]       shown_ff;
   logic [1:0]       sprio_ff;
   logic             changed_ff;

   logic             is_set, is_clear, is_reset, code_ok, eff, full;
   logic [1:0]       code_prio;
   logic [CNT_W-1:0] wpos;
   logic [IDX_W-1:0] widx;
   logic [3:0]       ent;
   logic [1:0]       ent_prio;
   logic             excl;
   logic [3:0]       before_code, after_code;
   logic             status_w;

   assign is_set   = (op_ff == pss_pkg::CMD_SET);
   assign is_clear = (op_ff == pss_pkg::CMD_CLEAR);
   assign is_reset = (op_ff == pss_pkg::CMD_RESET);
   assign code_ok  = (code_ff != 4'd0) && ({1'b0, code_ff} < state_limit)
                     && ({1'b0, code_ff} < 5'(pss_pkg::CODE_COUNT));
   assign code_prio = pss_pkg::prio_of(priority_map, code_ff);
   assign eff      = code_ok && (code_prio != pss_pkg::PRIO_IGNORE);
   assign full     = (count_ff == DEPTH_C);

   assign dp_stat.walk_done = (left_ff == '0);

   // walk one entry a cycle from the newest down
   assign wpos     = left_ff - 1'b1;
   assign widx     = wpos[IDX_W-1:0];
   assign ent      = stack_ff[widx];
   assign ent_prio = pss_pkg::prio_of(priority_map, ent);
   // entry dropped by this request: evicted oldest, or newest match
   assign excl = (is_set && eff && full && (widx == '0))
              || (is_clear && eff && !mfound_ff && (ent == code_ff));

   for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_up
      if (g < STACK_DEPTH - 1) begin : g_mid
         assign up_w[g] = stack_ff[g+1];
      end else begin : g_top
         assign up_w[g] = code_ff;
      end
   end

   assign before_code = bfound_ff ? bbest_ff : off_code;

   always_comb begin
      if (is_reset) begin
         after_code = off_code;
      end else if (is_set && eff) begin
         // new code is the most recent, so it wins ties
         after_code = (!afound_ff || (code_prio >= aprio_ff)) ? code_ff : abest_ff;
      end else begin
         after_code = afound_ff ? abest_ff : off_code;
      end
   end

   assign status_w = (is_set || is_clear)
                  && (!code_ok || (is_clear && eff && !mfound_ff))
                   ? pss_pkg::STATUS_ERROR : pss_pkg::STATUS_OK;

   always_comb begin
      for (int j = 0; j < STACK_DEPTH; j++) begin
         stack_in[j] = stack_ff[j];
         if (dp_cmd.apply && is_set && eff) begin
            if (full) stack_in[j] = up_w[j];
            else if (count_ff == CNT_W'(j)) stack_in[j] = code_ff;
         end else if (dp_cmd.apply && is_clear && eff && mfound_ff) begin
            if (IDX_W'(j) >= midx_ff) stack_in[j] = up_w[j];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (dp_cmd.apply) begin
         if (is_reset) count_in = '0;
         else if (is_set && eff && !full) count_in = count_ff + 1'b1;
         else if (is_clear && eff && mfound_ff) count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      left_in = left_ff;
      if (dp_cmd.start) left_in = count_ff;
      else if (dp_cmd.step) left_in = wpos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         left_ff  <= '0;
      end else begin
         count_ff <= count_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < STACK_DEPTH; j++) stack_ff[j] <= stack_in[j];
      if (dp_cmd.start) begin
         op_ff     <= req_cmd;
         code_ff   <= req_led_code;
         bfound_ff <= 1'b0;
         afound_ff <= 1'b0;
         mfound_ff <= 1'b0;
      end else if (dp_cmd.step) begin
         if (!bfound_ff || (ent_prio > bprio_ff)) begin
            bbest_ff  <= ent;
            bprio_ff  <= ent_prio;
            bfound_ff <= 1'b1;
         end
         if (excl) begin
            if (is_clear) begin
               mfound_ff <= 1'b1;
               midx_ff   <= widx;
            end
         end else if (!afound_ff || (ent_prio > aprio_ff)) begin
            abest_ff  <= ent;
            aprio_ff  <= ent_prio;
            afound_ff <= 1'b1;
         end
      end
      if (dp_cmd.apply) begin
         status_ff  <= status_w;
         shown_ff   <= after_code;
         sprio_ff   <= pss_pkg::prio_of(priority_map, after_code);
         changed_ff <= (after_code != before_code);
      end
   end

   assign rsp_status          = status_ff;
   assign rsp_shown_code      = shown_ff;
   assign rsp_shown_priority  = sprio_ff;
   assign rsp_display_changed = changed_ff;

endmodule

// ----- rtl/core/priority_status_stack_top.sv -----
// Priority status stack: keeps a recency-ordered stack of requested
// indicator codes and reports the code to display.
//
// Request channel (req_*): a word carries a command (set, clear, reset,
// query) and a state code; it is taken at a clock edge with req_valid
// high and req_stall low. Result channel (rsp_*): one word per request
// with status, shown code, its priority and a display-changed flag.
// Configuration goes through the APB-style port: priority map at byte
// address 0, state limit at 4, off code at 8.
//
// Sequence: after accept the datapath walks the N stack entries (N at
// most STACK_DEPTH), one entry examined per cycle, then applies the
// update and loads the result word. No new request is taken until the
// word is loaded; req_stall stays high for the whole walk.
//
// Reset empties the stack, loads the register reset values and drops any
// pending result. While the receiver stalls, the result word holds; a
// following request is walked and then waits until the word is taken.
module priority_status_stack_top #(
   parameter int STACK_DEPTH = 10
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [3:0]  req_led_code,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [3:0]  rsp_shown_code,
   output logic [1:0]  rsp_shown_priority,
   output logic        rsp_display_changed,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [31:0] priority_map_ff, priority_map_in;
   logic [4:0]  state_limit_ff, state_limit_in;
   logic [3:0]  off_code_ff, off_code_in;
   logic        csr_write;
   logic [1:0]  csr_index;

   pss_pkg::dp_cmd_type  dp_cmd;
   pss_pkg::dp_stat_type dp_stat;

   // register file: zero-wait APB, write in the access cycle
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_comb begin
      priority_map_in = priority_map_ff;
      state_limit_in  = state_limit_ff;
      off_code_in     = off_code_ff;
      if (csr_write) begin
         unique case (csr_index)
            pss_pkg::CSR_PRIORITY_MAP: priority_map_in = pwdata;
            pss_pkg::CSR_STATE_LIMIT:  state_limit_in  = pwdata[4:0];
            pss_pkg::CSR_OFF_CODE:     off_code_in     = pwdata[3:0];
            default: begin
               // unmapped address: drop the write
               priority_map_in = priority_map_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         pss_pkg::CSR_PRIORITY_MAP: prdata = priority_map_ff;
         pss_pkg::CSR_STATE_LIMIT:  prdata = {27'd0, state_limit_ff};
         pss_pkg::CSR_OFF_CODE:     prdata = {28'd0, off_code_ff};
         default:                   prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         priority_map_ff <= pss_pkg::PRIORITY_MAP_RST;
         state_limit_ff  <= pss_pkg::STATE_LIMIT_RST;
         off_code_ff     <= pss_pkg::OFF_CODE_RST;
      end else begin
         priority_map_ff <= priority_map_in;
         state_limit_ff  <= state_limit_in;
         off_code_ff     <= off_code_in;
      end
   end

   // sequencer: accept, walk, apply
   pss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   // stack, selection walk and result word
   pss_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .dp_cmd              (dp_cmd),
      .dp_stat             (dp_stat),
      .req_cmd             (req_cmd),
      .req_led_code        (req_led_code),
      .priority_map        (priority_map_ff),
      .state_limit         (state_limit_ff),
      .off_code            (off_code_ff),
      .rsp_status          (rsp_status),
      .rsp_shown_code      (rsp_shown_code),
      .rsp_shown_priority  (rsp_shown_priority),
      .rsp_display_changed (rsp_display_changed)
   );

endmodule

// ----- rtl/core/pss_checker.sv -----
module pss_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_shown_priority
);

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // one request at a time: the walk blocks the next word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // a high priority of three is reported as two
   a_prio_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_shown_priority != pss_pkg::PRIO_HIGH_ALT)
      else $error("shown priority out of range");

   // reset drops any pending result
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind priority_status_stack_top pss_checker u_pss_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_shown_priority (rsp_shown_priority)
);

// ----- sim/testbench.sv -----
module testbench;

   localparam int STACK_DEPTH = 10;
   localparam int PLAN_ROWS   = 23;
   localparam int PHASES      = 6;

   // one result word as the block reports it
   typedef struct packed {
      logic       status;
      logic [3:0] code;
      logic [1:0] level;
      logic       changed;
   } display_word_type;

   // one row of the directed plan; the word is only meaningful when typed is set
   typedef struct packed {
      logic [1:0]       cmd;
      logic [3:0]       code;
      logic             typed;
      display_word_type want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = pss_pkg::CMD_QUERY;
   logic [3:0]  req_led_code = 4'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_status;
   logic [3:0]  rsp_shown_code;
   logic [1:0]  rsp_shown_priority;
   logic        rsp_display_changed;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = 4'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // mirror of the block: registers and the code stack, oldest entry at index 0
   logic [31:0] map_q   = pss_pkg::PRIORITY_MAP_RST;
   logic [4:0]  limit_q = pss_pkg::STATE_LIMIT_RST;
   logic [3:0]  off_q   = pss_pkg::OFF_CODE_RST;
   logic [3:0]  stack_q [STACK_DEPTH];
   int          held = 0;

   display_word_type awaited_words [$];
   display_word_type got_word, want_word;
   int          mismatch_count = 0;
   int          words_checked = 0;
   int          send_idle = 0;
   int          recv_idle = 0;

   priority_status_stack_top #(.STACK_DEPTH(STACK_DEPTH)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_cmd), .req_led_code(req_led_code),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_shown_code(rsp_shown_code),
      .rsp_shown_priority(rsp_shown_priority),
      .rsp_display_changed(rsp_display_changed),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // count a mismatch; report true while still within the print budget
   function automatic bit tally_mismatch();
      mismatch_count++;
      return mismatch_count <= 10;
   endfunction

   // level of a code under the current map; level three reads as high
   function automatic logic [1:0] level_of(input logic [3:0] code);
      logic [1:0] raw;
      raw = map_q[2 * code +: 2];
      return (raw == pss_pkg::PRIO_HIGH_ALT) ? pss_pkg::PRIO_HIGH : raw;
   endfunction

   // newest entry of the top level wins; empty stack shows the off code
   function automatic logic [3:0] shown_code_now();
      logic [3:0] best;
      logic [1:0] best_level;
      bit         found;
      best = off_q;
      best_level = pss_pkg::PRIO_IGNORE;
      found = 1'b0;
      for (int i = held - 1; i >= 0; i--) begin
         if (!found || level_of(stack_q[i]) > best_level) begin
            best = stack_q[i];
            best_level = level_of(stack_q[i]);
            found = 1'b1;
         end
      end
      return best;
   endfunction

   // close the gap left by the entry at pos
   task automatic drop_entry(input int pos);
      for (int j = pos; j + 1 < held; j++) stack_q[j] = stack_q[j + 1];
      held--;
   endtask

   // advance the mirror by one request and work out the word it yields
   task automatic apply_request(input logic [1:0] cmd, input logic [3:0] code,
                                output display_word_type w);
      logic [3:0] prior;
      int         hit;
      prior = shown_code_now();
      w.status = pss_pkg::STATUS_OK;
      hit = -1;
      case (cmd)
         pss_pkg::CMD_RESET: begin
            held = 0;
         end
         pss_pkg::CMD_SET, pss_pkg::CMD_CLEAR: begin
            if (code == 4'd0 || code >= limit_q || code >= pss_pkg::CODE_COUNT) begin
               w.status = pss_pkg::STATUS_ERROR;
            end else if (level_of(code) != pss_pkg::PRIO_IGNORE) begin
               if (cmd == pss_pkg::CMD_SET) begin
                  if (held >= STACK_DEPTH) drop_entry(0);
                  stack_q[held] = code;
                  held++;
               end else begin
                  for (int i = held - 1; i >= 0; i--)
                     if (hit < 0 && stack_q[i] == code) hit = i;
                  if (hit < 0) w.status = pss_pkg::STATUS_ERROR;
                  else drop_entry(hit);
               end
            end
         end
         default: ;
      endcase
      w.code = shown_code_now();
      w.level = level_of(w.code);
      w.changed = (w.code != prior);
   endtask

   // one APB transfer: setup, access, then release; entered anywhere, left at a falling edge
   task automatic csr_cycle(input logic wr, input logic [1:0] idx,
                            input logic [31:0] data, output logic [31:0] rd);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // write a register, mirror it, then read it back
   task automatic program_register(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] want;
      csr_cycle(1'b1, idx, value, readback);
      case (idx)
         pss_pkg::CSR_PRIORITY_MAP: map_q = value;
         pss_pkg::CSR_STATE_LIMIT:  limit_q = value[4:0];
         default:                   off_q = value[3:0];
      endcase
      want = (idx == pss_pkg::CSR_PRIORITY_MAP) ? map_q :
             (idx == pss_pkg::CSR_STATE_LIMIT) ? {27'd0, limit_q} : {28'd0, off_q};
      csr_cycle(1'b0, idx, 32'd0, readback);
      if (readback !== want)
         if (tally_mismatch())
            $display("register %0d read back %h, want %h", idx, readback, want);
   endtask

   // present one request word, hold it until taken, then log what it must yield;
   // entered and left at a falling edge
   task automatic send_word(input logic [1:0] cmd, input logic [3:0] code,
                            input logic typed, input display_word_type typed_word);
      display_word_type w;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_led_code <= code;
      do @(posedge clock); while (req_stall);
      apply_request(cmd, code, w);
      awaited_words.push_back(typed ? typed_word : w);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (awaited_words.size() != 0) @(posedge clock);
   endtask

   // receiver: stall at random, decided at the falling edge
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_idle);

   // check every result word taken against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_word = {rsp_status, rsp_shown_code, rsp_shown_priority, rsp_display_changed};
         if (awaited_words.size() == 0) begin
            if (tally_mismatch())
               $display("unexpected word: status %0d code %0d level %0d changed %0d",
                        got_word.status, got_word.code, got_word.level, got_word.changed);
         end else begin
            want_word = awaited_words.pop_front();
            if (got_word !== want_word)
               if (tally_mismatch())
                  $display("word %0d: want %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                           words_checked, want_word.status, want_word.code,
                           want_word.level, want_word.changed, got_word.status,
                           got_word.code, got_word.level, got_word.changed);
         end
         words_checked++;
      end
   end

   initial begin
      plan_row_type plan [PLAN_ROWS];
      logic [31:0] map_v;
      logic [4:0]  limit_v;
      logic [3:0]  off_v;
      logic [1:0]  cmd;
      logic [3:0]  code;
      int          roll;
      int          count;

      // directed plan under the reset settings: every code defaults, limit 16, off code 1
      plan = '{
         // query on an empty stack shows the off code
         {pss_pkg::CMD_QUERY, 4'd9, 1'b1,
          pss_pkg::STATUS_OK, 4'd1, pss_pkg::PRIO_DEFAULT, 1'b0},
         // code zero is out of range
         {pss_pkg::CMD_SET, 4'd0, 1'b1,
          pss_pkg::STATUS_ERROR, 4'd1, pss_pkg::PRIO_DEFAULT, 1'b0},
         // clear with nothing on the stack
         {pss_pkg::CMD_CLEAR, 4'd5, 1'b1,
          pss_pkg::STATUS_ERROR, 4'd1, pss_pkg::PRIO_DEFAULT, 1'b0},
         // top code, then a newer one of equal level takes over
         {pss_pkg::CMD_SET, 4'd15, 1'b1,
          pss_pkg::STATUS_OK, 4'd15, pss_pkg::PRIO_DEFAULT, 1'b1},
         {pss_pkg::CMD_SET, 4'd1, 1'b1,
          pss_pkg::STATUS_OK, 4'd1, pss_pkg::PRIO_DEFAULT, 1'b1},
         {pss_pkg::CMD_CLEAR, 4'd1, 1'b1,
          pss_pkg::STATUS_OK, 4'd15, pss_pkg::PRIO_DEFAULT, 1'b1},
         {pss_pkg::CMD_CLEAR, 4'd3, 1'b1,
          pss_pkg::STATUS_ERROR, 4'd15, pss_pkg::PRIO_DEFAULT, 1'b0},
         // overfill the stack so the oldest entries are evicted
         {pss_pkg::CMD_SET,   4'd2,  1'b0, 8'h00},
         {pss_pkg::CMD_SET,   4'd3,  1'b0, 8'h00},
         {pss_pkg::CMD_SET,   4'd4,  1'b0, 8'h00},
         {pss_pkg::CMD_SET,   4'd5,  1'b0, 8'h00},
         {pss_pkg::CMD_SET,   4'd6,  1'b0, 8'h00},
         {pss_pkg::CMD_SET,   4'd7,  1'b0, 8'h00},
         {pss_pkg::CMD_SET,   4'd8,  1'b0, 8'h00},
         {pss_pkg::CMD_SET,   4'd9,  1'b0, 8'h00},
         {pss_pkg::CMD_SET,   4'd10, 1'b0, 8'h00},
         {pss_pkg::CMD_SET,   4'd11, 1'b0, 8'h00},
         {pss_pkg::CMD_SET,   4'd12, 1'b0, 8'h00},
         // an evicted code can no longer be cleared
         {pss_pkg::CMD_CLEAR, 4'd2,  1'b0, 8'h00},
         {pss_pkg::CMD_QUERY, 4'd15, 1'b0, 8'h00},
         // empty the stack, twice
         {pss_pkg::CMD_RESET, 4'd15, 1'b1,
          pss_pkg::STATUS_OK, 4'd1, pss_pkg::PRIO_DEFAULT, 1'b1},
         {pss_pkg::CMD_RESET, 4'd0, 1'b1,
          pss_pkg::STATUS_OK, 4'd1, pss_pkg::PRIO_DEFAULT, 1'b0},
         // leave one entry on the stack for the settings that follow
         {pss_pkg::CMD_SET, 4'd7, 1'b1,
          pss_pkg::STATUS_OK, 4'd7, pss_pkg::PRIO_DEFAULT, 1'b1}
      };

      // hold reset, then release it on a falling edge
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // sender idles with odds of 32 in a hundred, receiver with 60
      send_idle = 32;
      recv_idle = 60;
      foreach (plan[i]) send_word(plan[i].cmd, plan[i].code, plan[i].typed, plan[i].want);
      req_valid <= 1'b0;
      wait_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         // pick the settings: the extremes first, then random mixes of levels
         case (ph)
            0: begin map_v = 32'hFFFF_FFFF; limit_v = 5'd16; off_v = 4'd0;  end
            1: begin map_v = 32'h0000_0000; limit_v = 5'd16; off_v = 4'd15; end
            2: begin map_v = $urandom(); limit_v = 5'd1; off_v = 4'($urandom()); end
            3: begin
               map_v = $urandom();
               limit_v = 5'($urandom_range(16, 2));
               off_v = 4'($urandom());
            end
            4: begin map_v = $urandom(); limit_v = 5'd16; off_v = 4'($urandom()); end
            default: begin
               map_v = $urandom();
               limit_v = 5'($urandom_range(15, 2));
               off_v = 4'($urandom());
            end
         endcase
         // write registers only while the block has nothing in flight
         program_register(pss_pkg::CSR_PRIORITY_MAP, map_v);
         program_register(pss_pkg::CSR_STATE_LIMIT, {27'd0, limit_v});
         program_register(pss_pkg::CSR_OFF_CODE, {28'd0, off_v});

         // swap idling sides after the first two phases, then run the last two without idling
         if (ph < 2) begin
            send_idle = 32;
            recv_idle = 60;
         end else if (ph < 4) begin
            send_idle = 60;
            recv_idle = 32;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end

         // with a limit of one every set and clear fails, so keep that phase short
         count = (limit_v == 5'd1) ? 50 : 140;
         repeat (count) begin
            roll = $urandom_range(99);
            cmd = (roll < 45) ? pss_pkg::CMD_SET : (roll < 75) ? pss_pkg::CMD_CLEAR :
                  (roll < 80) ? pss_pkg::CMD_RESET : pss_pkg::CMD_QUERY;
            // mostly codes in range; clears mostly target a code on the stack
            roll = $urandom_range(99);
            if (cmd == pss_pkg::CMD_CLEAR && held > 0 && roll < 60)
               code = stack_q[$urandom_range(held - 1)];
            else if (roll < 85 && limit_q > 5'd1)
               code = 4'($urandom_range(limit_q - 1, 1));
            else
               code = 4'($urandom());
            send_word(cmd, code, 1'b0, 8'h00);
         end
         req_valid <= 1'b0;
         wait_drained();
      end

      // let any stray word surface before the verdict
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && awaited_words.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
